// ===== rtl/core/splim_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak limiter package
// Shared widths, constants, register indexes and controller/datapath types.
// ----------------------------------------------------------------------------
package splim_pkg;

  localparam int SAMPLE_IN_W  = 24;
  localparam int SAMPLE_OUT_W = 22;
  localparam int MAG_W        = 24;
  localparam int COEF_W       = 24;
  localparam int FADE_W       = 25;
  localparam int CEIL_W       = 21;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 25;
  localparam int PROD_W       = MAG_W + FADE_W;
  localparam int DIV_STEPS    = 24;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int KNEE_FRAC    = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd3;

  localparam logic              BYPASS_RST  = 1'b0;
  localparam logic [COEF_W-1:0] RELEASE_RST = 24'd16760439;
  localparam logic [FADE_W-1:0] FADE_RST    = 25'd16777216;
  localparam logic [CEIL_W-1:0] CEILING_RST = 21'd996147;

  localparam logic [MAG_W-1:0]  ONE_Q20   = 24'd1048576;
  localparam logic [FADE_W-1:0] ONE_Q24   = 25'd16777216;
  localparam logic [MAG_W-1:0]  CLIP_LIN  = 24'd838861;
  localparam logic [MAG_W-1:0]  CLIP_KNEE = 24'd209715;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ENV_SET,
    OP_ENV_MUL,
    OP_ENV_WB,
    OP_GDIV_INIT,
    OP_DIV_STEP,
    OP_GAIN_MUL,
    OP_GAIN_WB,
    OP_KNEE_MUL,
    OP_KDIV_INIT,
    OP_KNEE_WB,
    OP_FADE_MUL,
    OP_FADE_WB,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   ch;
  } dp_cmd_t;

  typedef struct packed {
    logic bypass;
    logic env_rise;
    logic env_over;
    logic knee;
    logic out_full;
  } dp_stat_t;

endpackage

// ===== rtl/core/splim_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak limiter channel interfaces
// Valid/ready channels for the input bus pair and the processed output pair.
// ----------------------------------------------------------------------------
interface splim_in_if;
  import splim_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_IN_W-1:0] bus_left;
  logic signed [SAMPLE_IN_W-1:0] bus_right;

  modport source (output valid, output bus_left, output bus_right, input ready);
  modport sink (input valid, input bus_left, input bus_right, output ready);
endinterface

interface splim_out_if;
  import splim_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_OUT_W-1:0] out_left;
  logic signed [SAMPLE_OUT_W-1:0] out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink (input valid, input out_left, input out_right, output ready);
endinterface

// ===== rtl/core/splim_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak limiter controller
// Sequences envelope, gain division, soft clip, fade and output steps.
// ----------------------------------------------------------------------------
module splim_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  splim_pkg::dp_stat_t stat,
  output splim_pkg::dp_cmd_t  cmd
);
  import splim_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_ENV       = 14'b00000000000010,
    S_ENV_WB    = 14'b00000000000100,
    S_GCHK      = 14'b00000000001000,
    S_GDIV      = 14'b00000000010000,
    S_GAIN_MUL  = 14'b00000000100000,
    S_GAIN_WB   = 14'b00000001000000,
    S_KNEE      = 14'b00000010000000,
    S_KDIV_INIT = 14'b00000100000000,
    S_KDIV      = 14'b00001000000000,
    S_KNEE_WB   = 14'b00010000000000,
    S_FADE_MUL  = 14'b00100000000000,
    S_FADE_WB   = 14'b01000000000000,
    S_OUT       = 14'b10000000000000
  } state_t;

  state_t               state_r, state_nxt;
  logic                 ch_r, ch_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 cnt_last;

  assign cnt_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    cnt_nxt   = cnt_r;
    cmd.op    = OP_NONE;
    cmd.ch    = ch_r;
    case (state_r)
      S_IDLE: begin
        ch_nxt = 1'b0;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = stat.bypass ? S_FADE_MUL : S_ENV;
        end
      end
      S_ENV: begin
        if (stat.env_rise) begin
          cmd.op    = OP_ENV_SET;
          state_nxt = S_GCHK;
        end else begin
          cmd.op    = OP_ENV_MUL;
          state_nxt = S_ENV_WB;
        end
      end
      S_ENV_WB: begin
        cmd.op    = OP_ENV_WB;
        state_nxt = S_GCHK;
      end
      S_GCHK: begin
        cnt_nxt = '0;
        if (stat.env_over) begin
          cmd.op    = OP_GDIV_INIT;
          state_nxt = S_GDIV;
        end else begin
          state_nxt = S_KNEE;
        end
      end
      S_GDIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = S_GAIN_MUL;
        end
      end
      S_GAIN_MUL: begin
        cmd.op    = OP_GAIN_MUL;
        state_nxt = S_GAIN_WB;
      end
      S_GAIN_WB: begin
        cmd.op = OP_GAIN_WB;
        ch_nxt = ~ch_r;
        state_nxt = ch_r ? S_KNEE : S_GAIN_MUL;
      end
      S_KNEE: begin
        if (stat.knee) begin
          cmd.op    = OP_KNEE_MUL;
          state_nxt = S_KDIV_INIT;
        end else begin
          ch_nxt = ~ch_r;
          if (ch_r) begin
            state_nxt = S_FADE_MUL;
          end
        end
      end
      S_KDIV_INIT: begin
        cmd.op    = OP_KDIV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_KDIV;
      end
      S_KDIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_last) begin
          state_nxt = S_KNEE_WB;
        end
      end
      S_KNEE_WB: begin
        cmd.op    = OP_KNEE_WB;
        ch_nxt    = ~ch_r;
        state_nxt = ch_r ? S_FADE_MUL : S_KNEE;
      end
      S_FADE_MUL: begin
        cmd.op    = OP_FADE_MUL;
        state_nxt = S_FADE_WB;
      end
      S_FADE_WB: begin
        cmd.op    = OP_FADE_WB;
        ch_nxt    = ~ch_r;
        state_nxt = ch_r ? S_OUT : S_FADE_MUL;
      end
      S_OUT: begin
        if (!stat.out_full) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/splim_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak limiter datapath
// Configuration registers, envelope and fade state, shared multiplier,
// radix-2 restoring divider and the output register.
// ----------------------------------------------------------------------------
module splim_dp (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [splim_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [splim_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic signed [splim_pkg::SAMPLE_IN_W-1:0] in_left,
  input  logic signed [splim_pkg::SAMPLE_IN_W-1:0] in_right,
  input  logic                                     out_ready,
  output logic                                     out_valid,
  output logic signed [splim_pkg::SAMPLE_OUT_W-1:0] out_left,
  output logic signed [splim_pkg::SAMPLE_OUT_W-1:0] out_right,
  input  splim_pkg::dp_cmd_t                       cmd,
  output splim_pkg::dp_stat_t                      stat
);
  import splim_pkg::*;

  logic              bypass_r, bypass_nxt;
  logic [COEF_W-1:0] rcoef_r, rcoef_nxt;
  logic [FADE_W-1:0] fstep_r, fstep_nxt;
  logic [CEIL_W-1:0] ceil_r, ceil_nxt;
  logic [MAG_W-1:0]  env_r, env_nxt;
  logic [FADE_W-1:0] fade_r, fade_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [MAG_W-1:0]        mag_r [2];
  logic [MAG_W-1:0]        mag_nxt [2];
  logic [1:0]              neg_r, neg_nxt;
  logic [MAG_W-1:0]        peak_r, peak_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic [MAG_W-1:0]        rem_r, rem_nxt;
  logic [MAG_W-1:0]        quo_r, quo_nxt;
  logic [MAG_W-1:0]        den_r, den_nxt;
  logic [SAMPLE_OUT_W-1:0] outl_r, outl_nxt;
  logic [SAMPLE_OUT_W-1:0] outr_r, outr_nxt;

  logic [MAG_W-1:0]  in_mag_l, in_mag_r;
  logic [MAG_W-1:0]  mag_cur;
  logic [MAG_W-1:0]  over;
  logic [MAG_W-1:0]  mul_a;
  logic [FADE_W-1:0] mul_b;
  logic [MAG_W:0]    div_t;
  logic [MAG_W:0]    div_d;
  logic              div_ge;
  logic [FADE_W-1:0] fade_prod;
  logic [FADE_W:0]   fade_sum;

  assign in_mag_l  = in_left[SAMPLE_IN_W-1] ? MAG_W'(~in_left + 1'b1) : MAG_W'(in_left);
  assign in_mag_r  = in_right[SAMPLE_IN_W-1] ? MAG_W'(~in_right + 1'b1) : MAG_W'(in_right);
  assign mag_cur   = mag_r[cmd.ch];
  assign over      = mag_cur - CLIP_LIN;
  assign div_t     = {rem_r, quo_r[MAG_W-1]};
  assign div_d     = div_t - {1'b0, den_r};
  assign div_ge    = (div_t >= {1'b0, den_r});
  assign fade_prod = prod_r[PROD_W-1:24];
  assign fade_sum  = {1'b0, fade_r} + {1'b0, fstep_r};

  assign stat.bypass   = bypass_r;
  assign stat.env_rise = (peak_r > env_r);
  assign stat.env_over = (env_r > MAG_W'(ceil_r));
  assign stat.knee     = (mag_cur > CLIP_LIN);
  assign stat.out_full = out_valid_r & ~out_ready;

  assign out_valid = out_valid_r;
  assign out_left  = outl_r;
  assign out_right = outr_r;

  always_comb begin
    case (cmd.op)
      OP_ENV_MUL: begin
        mul_a = env_r - peak_r;
        mul_b = {1'b0, rcoef_r};
      end
      OP_GAIN_MUL: begin
        mul_a = mag_cur;
        mul_b = {1'b0, quo_r};
      end
      OP_KNEE_MUL: begin
        mul_a = over;
        mul_b = {1'b0, CLIP_KNEE};
      end
      default: begin
        mul_a = mag_cur;
        mul_b = fade_r;
      end
    endcase
  end

  always_comb begin
    bypass_nxt    = bypass_r;
    rcoef_nxt     = rcoef_r;
    fstep_nxt     = fstep_r;
    ceil_nxt      = ceil_r;
    env_nxt       = env_r;
    fade_nxt      = fade_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    mag_nxt[0]    = mag_r[0];
    mag_nxt[1]    = mag_r[1];
    neg_nxt       = neg_r;
    peak_nxt      = peak_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    den_nxt       = den_r;
    outl_nxt      = outl_r;
    outr_nxt      = outr_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_BYPASS:  bypass_nxt = cfg_data[0];
        CFG_RELEASE: rcoef_nxt  = cfg_data[COEF_W-1:0];
        CFG_FADE:    fstep_nxt  = cfg_data[FADE_W-1:0];
        CFG_CEILING: ceil_nxt   = cfg_data[CEIL_W-1:0];
        default: ;
      endcase
    end

    case (cmd.op)
      OP_LOAD: begin
        mag_nxt[0] = in_mag_l;
        mag_nxt[1] = in_mag_r;
        neg_nxt    = {in_right[SAMPLE_IN_W-1], in_left[SAMPLE_IN_W-1]};
        peak_nxt   = (in_mag_l > in_mag_r) ? in_mag_l : in_mag_r;
      end
      OP_ENV_SET: begin
        env_nxt = peak_r;
      end
      OP_ENV_MUL, OP_GAIN_MUL, OP_KNEE_MUL, OP_FADE_MUL: begin
        prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      OP_ENV_WB: begin
        env_nxt = peak_r + prod_r[47:24];
      end
      OP_GDIV_INIT: begin
        rem_nxt = MAG_W'(ceil_r);
        quo_nxt = '0;
        den_nxt = env_r;
      end
      OP_DIV_STEP: begin
        rem_nxt = div_ge ? div_d[MAG_W-1:0] : div_t[MAG_W-1:0];
        quo_nxt = {quo_r[MAG_W-2:0], div_ge};
      end
      OP_GAIN_WB: begin
        mag_nxt[cmd.ch] = prod_r[47:24];
      end
      OP_KDIV_INIT: begin
        rem_nxt = prod_r[41:18];
        quo_nxt = {prod_r[17:0], KNEE_FRAC'(0)};
        den_nxt = over + CLIP_KNEE;
      end
      OP_KNEE_WB: begin
        mag_nxt[cmd.ch] = CLIP_LIN + MAG_W'(quo_r[MAG_W-1:KNEE_FRAC]);
      end
      OP_FADE_WB: begin
        mag_nxt[cmd.ch] = (fade_prod > FADE_W'(ONE_Q20)) ? ONE_Q20 : fade_prod[MAG_W-1:0];
      end
      OP_OUT: begin
        outl_nxt      = neg_r[0] ? SAMPLE_OUT_W'(~mag_r[0] + 1'b1) : mag_r[0][SAMPLE_OUT_W-1:0];
        outr_nxt      = neg_r[1] ? SAMPLE_OUT_W'(~mag_r[1] + 1'b1) : mag_r[1][SAMPLE_OUT_W-1:0];
        out_valid_nxt = 1'b1;
        if (fade_r < ONE_Q24) begin
          fade_nxt = (fade_sum > {1'b0, ONE_Q24}) ? ONE_Q24 : fade_sum[FADE_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r    <= BYPASS_RST;
      rcoef_r     <= RELEASE_RST;
      fstep_r     <= FADE_RST;
      ceil_r      <= CEILING_RST;
      env_r       <= '0;
      fade_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bypass_r    <= bypass_nxt;
      rcoef_r     <= rcoef_nxt;
      fstep_r     <= fstep_nxt;
      ceil_r      <= ceil_nxt;
      env_r       <= env_nxt;
      fade_r      <= fade_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r[0] <= mag_nxt[0];
    mag_r[1] <= mag_nxt[1];
    neg_r    <= neg_nxt;
    peak_r   <= peak_nxt;
    prod_r   <= prod_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    den_r    <= den_nxt;
    outl_r   <= outl_nxt;
    outr_r   <= outr_nxt;
  end

endmodule

// ===== rtl/core/stereo_peak_limiter_softclip.sv =====
`timescale 1ns / 1ps
// The shared radix-2 divider runs up to three 24-step divisions per transaction (gain, then
// one knee per channel), and the single shared multiplier forms the envelope, gain, knee and
// fade products. A new transaction is taken as soon as the result is registered, while that
// result may still wait on the output. Synchronous active-low reset returns the configuration
// registers to defaults and clears envelope and fade.
// ----------------------------------------------------------------------------
// Stereo peak limiter with soft clipper
// Top level: linked peak envelope limiter, soft knee clipper and start-up fade.
// ----------------------------------------------------------------------------
module stereo_peak_limiter_softclip (
  input  logic                             clk,
  input  logic                             rst_n,
  splim_in_if.sink                         in_chan,
  splim_out_if.source                      out_chan,
  input  logic                             cfg_we,
  input  logic [splim_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [splim_pkg::CFG_DATA_W-1:0] cfg_data
);
  import splim_pkg::*;

  dp_cmd_t                 cmd;
  dp_stat_t                stat;
  logic                    in_ready;
  logic                    out_valid;
  logic [SAMPLE_OUT_W-1:0] out_left;
  logic [SAMPLE_OUT_W-1:0] out_right;

  assign in_chan.ready      = in_ready;
  assign out_chan.valid     = out_valid;
  assign out_chan.out_left  = out_left;
  assign out_chan.out_right = out_right;

  splim_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  splim_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_left   (in_chan.bus_left),
    .in_right  (in_chan.bus_right),
    .out_ready (out_chan.ready),
    .out_valid (out_valid),
    .out_left  (out_left),
    .out_right (out_right),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== rtl/core/splim_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo peak limiter port checker
// Watches the top-level ports for ordering, bounds and reset behavior.
// ----------------------------------------------------------------------------
module splim_checker (
  input logic                                     clk,
  input logic                                     rst_n,
  input logic                                     in_valid,
  input logic                                     in_ready,
  input logic                                     out_valid,
  input logic                                     out_ready,
  input logic signed [splim_pkg::SAMPLE_OUT_W-1:0] out_left,
  input logic signed [splim_pkg::SAMPLE_OUT_W-1:0] out_right
);
  import splim_pkg::*;

  logic [1:0] pending_r, pending_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc      = in_valid & in_ready;
  assign out_acc     = out_valid & out_ready;
  assign pending_nxt = pending_r + {1'b0, in_acc} - {1'b0, out_acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output valid seen right after reset.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("Input accepted again before the previous transaction finished.");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("Result presented without an outstanding input transaction.");

  a_out_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left <= 22'sd1048576 && out_left >= -22'sd1048576 &&
                   out_right <= 22'sd1048576 && out_right >= -22'sd1048576))
    else $error("Output sample magnitude exceeds one.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right))
    else $error("Stalled output transaction changed.");

endmodule

bind stereo_peak_limiter_softclip splim_checker u_splim_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_left  (out_chan.out_left),
  .out_right (out_chan.out_right)
);
